FILE: rtl/qapm_pkg.sv
`timescale 1ns / 1ps

package qapm_pkg;

    // Field widths
    localparam int ERR_W    = 16;
    localparam int ACC_W    = 18;
    localparam int DIFF_W   = 17;
    localparam int GAIN_W   = 16;
    localparam int STICK_W  = 12;
    localparam int MOTOR_W  = 15;

    // Gain product widths: unsigned 16-bit gain times signed operand
    localparam int P_KP_W   = GAIN_W + 1 + ERR_W;
    localparam int P_KI_W   = GAIN_W + 1 + ACC_W;
    localparam int P_KD_W   = GAIN_W + 1 + DIFF_W;
    localparam int SUM_W    = 35;
    // |axis sum| stays below 2^34 for any gains and operands
    localparam int MAG_W    = 34;

    // Axis scaling: sum / (SCALE_DIV << frac bits), division by reciprocal
    localparam int SCALE_DIV   = 100;
    localparam int RECIP_EXTRA = 7;   // ceil(log2(SCALE_DIV))
    localparam int QUO_DROP    = 6;   // quotient loses at least this many bits

    // Stick handling
    localparam logic [STICK_W-1:0] DB_LOW    = 12'd1490;
    localparam logic [STICK_W-1:0] DB_HIGH   = 12'd1510;
    localparam logic [STICK_W-1:0] STICK_MID = 12'd1500;
    localparam logic [STICK_W-1:0] THR_MIN   = 12'd1200;

    // round(|d| * 100 / 13) = (|d| * 100 * R + 6 * R) >> 23, R = ceil(2^23 / 13)
    localparam int                OFF_SHIFT = 23;
    localparam int                OFF_W     = 15;
    localparam int                OFF_PW    = 38;
    localparam logic [25:0]       OFF_MUL   = 26'd64527800;
    localparam logic [21:0]       OFF_ADD   = 22'd3871668;

    // Integrator limits
    localparam logic signed [ERR_W-1:0] STEP_HI = 16'sd1000;
    localparam logic signed [ERR_W-1:0] STEP_LO = -16'sd1000;
    localparam logic signed [ACC_W-1:0] ACC_HI  = 18'sd100000;
    localparam logic signed [ACC_W-1:0] ACC_LO  = -18'sd100000;

    localparam int MOTOR_MAX = 32767;
    localparam logic [MOTOR_W-1:0] IDLE_RR = 15'd1001;
    localparam logic [MOTOR_W-1:0] IDLE_FR = 15'd1002;
    localparam logic [MOTOR_W-1:0] IDLE_RL = 15'd1003;
    localparam logic [MOTOR_W-1:0] IDLE_FL = 15'd1004;

    // Configuration register map
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL_KP  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL_KI  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL_KD  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_KP = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_KI = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_KD = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_KP   = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_KD   = 8'd7;

    localparam logic [GAIN_W-1:0] RST_ROLL_KP  = 16'd2048;
    localparam logic [GAIN_W-1:0] RST_ROLL_KI  = 16'd0;
    localparam logic [GAIN_W-1:0] RST_ROLL_KD  = 16'd0;
    localparam logic [GAIN_W-1:0] RST_PITCH_KP = 16'd2048;
    localparam logic [GAIN_W-1:0] RST_PITCH_KI = 16'd0;
    localparam logic [GAIN_W-1:0] RST_PITCH_KD = 16'd0;
    localparam logic [GAIN_W-1:0] RST_YAW_KP   = 16'd768;
    localparam logic [GAIN_W-1:0] RST_YAW_KD   = 16'd1280;

    // Pipeline stages
    localparam int PIPE_DEPTH = 8;
    localparam int ST_IN  = 0;
    localparam int ST_ERR = 1;
    localparam int ST_INT = 2;
    localparam int ST_MUL = 3;
    localparam int ST_SUM = 4;
    localparam int ST_RND = 5;
    localparam int ST_QUO = 6;
    localparam int ST_OUT = 7;

    typedef struct packed {
        logic signed [ERR_W-1:0] measured_roll;
        logic signed [ERR_W-1:0] measured_pitch;
        logic signed [ERR_W-1:0] measured_yaw;
        logic [STICK_W-1:0]      stick_roll;
        logic [STICK_W-1:0]      stick_pitch;
        logic [STICK_W-1:0]      stick_yaw;
        logic [STICK_W-1:0]      stick_throttle;
    } qapm_in_t;

    typedef struct packed {
        logic [MOTOR_W-1:0] motor_rear_right;
        logic [MOTOR_W-1:0] motor_front_right;
        logic [MOTOR_W-1:0] motor_rear_left;
        logic [MOTOR_W-1:0] motor_front_left;
    } qapm_out_t;

    // Load enables for the divider stages of one axis
    typedef struct packed {
        logic sum_en;
        logic round_en;
        logic quot_en;
    } qapm_div_en_t;

endpackage

FILE: rtl/qapm_stick_err.sv
`timescale 1ns / 1ps

module qapm_stick_err (
    input  logic signed [qapm_pkg::ERR_W-1:0]   meas,
    input  logic [qapm_pkg::STICK_W-1:0]        stick,
    input  logic                                deadband,
    output logic signed [qapm_pkg::ERR_W-1:0]   err
);
    import qapm_pkg::*;

    localparam logic signed [ERR_W+1:0] ERR_HI = 18'sd32767;
    localparam logic signed [ERR_W+1:0] ERR_LO = -18'sd32768;

    logic [STICK_W-1:0]       stick_eff;
    logic                     below;
    logic [STICK_W-1:0]       dmag;
    logic [OFF_PW-1:0]        prod;
    logic [OFF_W-1:0]         q;
    logic signed [ERR_W+1:0]  off;
    logic signed [ERR_W+1:0]  full;

    always_comb begin
        stick_eff = (deadband && stick > DB_LOW && stick < DB_HIGH) ? STICK_MID : stick;
        below     = stick_eff < STICK_MID;
        dmag      = below ? (STICK_MID - stick_eff) : (stick_eff - STICK_MID);
        prod      = OFF_PW'(dmag) * OFF_PW'(OFF_MUL) + OFF_PW'(OFF_ADD);
        q         = prod[OFF_SHIFT +: OFF_W];
        off       = below ? -$signed({3'b000, q}) : $signed({3'b000, q});
        full      = $signed({{2{meas[ERR_W-1]}}, meas}) - off;
        if (full > ERR_HI) begin
            err = ERR_W'(ERR_HI);
        end else if (full < ERR_LO) begin
            err = ERR_W'(ERR_LO);
        end else begin
            err = ERR_W'(full);
        end
    end

endmodule

FILE: rtl/qapm_axis_div.sv
`timescale 1ns / 1ps

module qapm_axis_div #(
    parameter  int GAIN_FRAC_BITS = 8,
    localparam int TW     = qapm_pkg::MAG_W - GAIN_FRAC_BITS,
    localparam int QW     = TW - qapm_pkg::QUO_DROP,
    localparam int AXIS_W = QW + 1
) (
    input  logic                                aclk,
    input  qapm_pkg::qapm_div_en_t              en,
    input  logic signed [qapm_pkg::SUM_W-1:0]   term_p,
    input  logic signed [qapm_pkg::SUM_W-1:0]   term_i,
    input  logic signed [qapm_pkg::SUM_W-1:0]   term_d,
    output logic signed [AXIS_W-1:0]            axis
);
    import qapm_pkg::*;

    // floor(t / 100) = (t * RECIP) >> K for every TW-bit t
    localparam int          K          = TW + RECIP_EXTRA;
    localparam int          PROD_W     = 2 * TW + 1;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << K) + 64'(SCALE_DIV - 1)) / 64'(SCALE_DIV);
    localparam logic [TW:0] RECIP_C    = RECIP_FULL[TW:0];
    localparam logic [MAG_W-1:0] HALF  = MAG_W'(SCALE_DIV / 2) << GAIN_FRAC_BITS;

    logic signed [SUM_W-1:0] sum_reg;
    logic [MAG_W-1:0]        mag;
    logic [MAG_W-1:0]        rnd;
    logic [TW-1:0]           t_reg;
    logic                    neg_t_reg;
    logic [PROD_W-1:0]       prod;
    logic [QW-1:0]           q_reg;
    logic                    neg_q_reg;

    // Round half away from zero on the magnitude, then drop the gain fraction
    assign mag  = sum_reg[SUM_W-1] ? MAG_W'(-sum_reg) : MAG_W'(sum_reg);
    assign rnd  = mag + HALF;
    assign prod = PROD_W'(t_reg) * PROD_W'(RECIP_C);
    assign axis = neg_q_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

    always_ff @(posedge aclk) begin
        if (en.sum_en) begin
            sum_reg <= term_p + term_i + term_d;
        end
        if (en.round_en) begin
            t_reg     <= rnd[MAG_W-1:GAIN_FRAC_BITS];
            neg_t_reg <= sum_reg[SUM_W-1];
        end
        if (en.quot_en) begin
            q_reg     <= prod[K +: QW];
            neg_q_reg <= neg_t_reg;
        end
    end

endmodule

FILE: rtl/qapm_mixer.sv
`timescale 1ns / 1ps

module qapm_mixer #(
    parameter int AXIS_W = 21
) (
    input  logic [qapm_pkg::STICK_W-1:0] thr,
    input  logic signed [AXIS_W-1:0]     roll,
    input  logic signed [AXIS_W-1:0]     pitch,
    input  logic signed [AXIS_W-1:0]     yaw,
    output qapm_pkg::qapm_out_t          motors
);
    import qapm_pkg::*;

    localparam int MW = AXIS_W + 3;
    localparam logic signed [MW-1:0] MAX_S = MW'(MOTOR_MAX);

    logic signed [MW-1:0] t;
    logic signed [MW-1:0] r;
    logic signed [MW-1:0] p;
    logic signed [MW-1:0] y;
    logic signed [MW-1:0] mix_rr;
    logic signed [MW-1:0] mix_fr;
    logic signed [MW-1:0] mix_rl;
    logic signed [MW-1:0] mix_fl;

    function automatic logic [MOTOR_W-1:0] sat_motor(input logic signed [MW-1:0] v);
        logic [MOTOR_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > MAX_S) begin
            res = MOTOR_W'(MAX_S);
        end else begin
            res = MOTOR_W'(v);
        end
        return res;
    endfunction

    always_comb begin
        t      = $signed({{(MW - STICK_W){1'b0}}, thr});
        r      = MW'(roll);
        p      = MW'(pitch);
        y      = MW'(yaw);
        mix_rr = t + p - r + y;
        mix_fr = t + p + r - y;
        mix_rl = t - p - r - y;
        mix_fl = t - p + r + y;
        if (thr > THR_MIN) begin
            motors.motor_rear_right  = sat_motor(mix_rr);
            motors.motor_front_right = sat_motor(mix_fr);
            motors.motor_rear_left   = sat_motor(mix_rl);
            motors.motor_front_left  = sat_motor(mix_fl);
        end else begin
            motors.motor_rear_right  = IDLE_RR;
            motors.motor_front_right = IDLE_FR;
            motors.motor_rear_left   = IDLE_RL;
            motors.motor_front_left  = IDLE_FL;
        end
    end

endmodule

FILE: rtl/quad_attitude_pid_mixer_unit.sv
`timescale 1ns / 1ps

// Quadcopter attitude controller with X-frame mixer. Each input transaction
// (three measured angles in centidegrees, four stick pulses in us) yields one
// output transaction of four motor pulses. The datapath is an eight-stage
// pipeline: input register, stick error, integrator update, gain multiplies,
// axis sum, rounding, reciprocal divide by 100 and mix/saturate. One
// transaction is taken every cycle unless the pipe is full and m_ready is
// low; integrators and previous errors update in a loop closed within the
// integrator stage, which is what lets ticks follow back to back. An empty
// stage lets the stage before it advance, so s_ready stays high as long as
// any stage is free. The user must write gains over the cfg port (index
// 0..7 in the order roll kp/ki/kd, pitch kp/ki/kd, yaw kp/kd) only while the
// pipe is empty; the block does not enforce this. Other indexes are ignored.
// GAIN_FRAC_BITS sets the gain fraction width (4..12).
module quad_attitude_pid_mixer_unit #(
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  qapm_pkg::qapm_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output qapm_pkg::qapm_out_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [qapm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [qapm_pkg::GAIN_W-1:0]         cfg_data
);
    import qapm_pkg::*;

    localparam int AXIS_W = MAG_W - GAIN_FRAC_BITS - QUO_DROP + 1;

    // Pipeline control
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;
    logic [PIPE_DEPTH-1:0] adv;

    // Gains
    logic [GAIN_W-1:0] roll_kp_reg;
    logic [GAIN_W-1:0] roll_ki_reg;
    logic [GAIN_W-1:0] roll_kd_reg;
    logic [GAIN_W-1:0] pitch_kp_reg;
    logic [GAIN_W-1:0] pitch_ki_reg;
    logic [GAIN_W-1:0] pitch_kd_reg;
    logic [GAIN_W-1:0] yaw_kp_reg;
    logic [GAIN_W-1:0] yaw_kd_reg;

    // Controller state
    logic signed [ACC_W-1:0] roll_accum_reg;
    logic signed [ACC_W-1:0] pitch_accum_reg;
    logic signed [ACC_W-1:0] roll_accum_next;
    logic signed [ACC_W-1:0] pitch_accum_next;
    logic signed [ERR_W-1:0] prev_roll_err_reg;
    logic signed [ERR_W-1:0] prev_pitch_err_reg;
    logic signed [ERR_W-1:0] prev_yaw_err_reg;

    // Stage payloads
    qapm_in_t                in_reg;
    logic [STICK_W-1:0]      thr_pipe_reg [ST_ERR:ST_QUO];
    logic signed [ERR_W-1:0] er_comb;
    logic signed [ERR_W-1:0] ep_comb;
    logic signed [ERR_W-1:0] ey_comb;
    logic signed [ERR_W-1:0] er1_reg;
    logic signed [ERR_W-1:0] ep1_reg;
    logic signed [ERR_W-1:0] ey1_reg;
    logic signed [ERR_W-1:0] er2_reg;
    logic signed [ERR_W-1:0] ep2_reg;
    logic signed [ERR_W-1:0] ey2_reg;
    logic signed [ACC_W-1:0] racc2_reg;
    logic signed [ACC_W-1:0] pacc2_reg;
    logic signed [DIFF_W-1:0] rdiff2_reg;
    logic signed [DIFF_W-1:0] pdiff2_reg;
    logic signed [DIFF_W-1:0] ydiff2_reg;

    logic signed [P_KP_W-1:0] rp_prod;
    logic signed [P_KI_W-1:0] ri_prod;
    logic signed [P_KD_W-1:0] rd_prod;
    logic signed [P_KP_W-1:0] pp_prod;
    logic signed [P_KI_W-1:0] pi_prod;
    logic signed [P_KD_W-1:0] pd_prod;
    logic signed [P_KP_W-1:0] yp_prod;
    logic signed [P_KD_W-1:0] yd_prod;
    logic signed [P_KP_W-1:0] rp_reg;
    logic signed [P_KI_W-1:0] ri_reg;
    logic signed [P_KD_W-1:0] rd_reg;
    logic signed [P_KP_W-1:0] pp_reg;
    logic signed [P_KI_W-1:0] pi_reg;
    logic signed [P_KD_W-1:0] pd_reg;
    logic signed [P_KP_W-1:0] yp_reg;
    logic signed [P_KD_W-1:0] yd_reg;

    qapm_div_en_t            div_en;
    logic signed [AXIS_W-1:0] roll_axis;
    logic signed [AXIS_W-1:0] pitch_axis;
    logic signed [AXIS_W-1:0] yaw_axis;
    qapm_out_t               mix_out;
    qapm_out_t               out_reg;

    function automatic logic signed [ACC_W-1:0] integrate(
        input logic signed [ACC_W-1:0] acc,
        input logic signed [ERR_W-1:0] e
    );
        logic signed [ERR_W-1:0] step;
        logic signed [ACC_W:0]   s;
        logic signed [ACC_W-1:0] res;
        if (e > STEP_HI) begin
            step = STEP_HI;
        end else if (e < STEP_LO) begin
            step = STEP_LO;
        end else begin
            step = e;
        end
        s = (ACC_W + 1)'(acc) + (ACC_W + 1)'(step);
        if (s > (ACC_W + 1)'(ACC_HI)) begin
            res = ACC_HI;
        end else if (s < (ACC_W + 1)'(ACC_LO)) begin
            res = ACC_LO;
        end else begin
            res = ACC_W'(s);
        end
        return res;
    endfunction

    // A stage may load when it is empty or its content moves on
    always_comb begin
        adv[ST_OUT] = !vld_reg[ST_OUT] || m_ready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k + 1];
        end
        vld_next[ST_IN] = adv[ST_IN] ? s_valid : vld_reg[ST_IN];
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            vld_next[k] = adv[k] ? vld_reg[k - 1] : vld_reg[k];
        end
    end

    assign s_ready   = adv[ST_IN];
    assign m_valid   = vld_reg[ST_OUT];
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    qapm_stick_err u_err_roll (
        .meas     (in_reg.measured_roll),
        .stick    (in_reg.stick_roll),
        .deadband (1'b1),
        .err      (er_comb)
    );

    qapm_stick_err u_err_pitch (
        .meas     (in_reg.measured_pitch),
        .stick    (in_reg.stick_pitch),
        .deadband (1'b1),
        .err      (ep_comb)
    );

    qapm_stick_err u_err_yaw (
        .meas     (in_reg.measured_yaw),
        .stick    (in_reg.stick_yaw),
        .deadband (1'b0),
        .err      (ey_comb)
    );

    // Integrators; low throttle clears them after the update
    always_comb begin
        roll_accum_next  = integrate(roll_accum_reg, er1_reg);
        pitch_accum_next = integrate(pitch_accum_reg, ep1_reg);
        if (thr_pipe_reg[ST_ERR] < THR_MIN) begin
            roll_accum_next  = '0;
            pitch_accum_next = '0;
        end
    end

    assign rp_prod = $signed({1'b0, roll_kp_reg}) * er2_reg;
    assign ri_prod = $signed({1'b0, roll_ki_reg}) * racc2_reg;
    assign rd_prod = $signed({1'b0, roll_kd_reg}) * rdiff2_reg;
    assign pp_prod = $signed({1'b0, pitch_kp_reg}) * ep2_reg;
    assign pi_prod = $signed({1'b0, pitch_ki_reg}) * pacc2_reg;
    assign pd_prod = $signed({1'b0, pitch_kd_reg}) * pdiff2_reg;
    assign yp_prod = $signed({1'b0, yaw_kp_reg}) * ey2_reg;
    assign yd_prod = $signed({1'b0, yaw_kd_reg}) * ydiff2_reg;

    always_comb begin
        div_en.sum_en   = adv[ST_SUM];
        div_en.round_en = adv[ST_RND];
        div_en.quot_en  = adv[ST_QUO];
    end

    qapm_axis_div #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_div_roll (
        .aclk   (aclk),
        .en     (div_en),
        .term_p (SUM_W'(rp_reg)),
        .term_i (SUM_W'(ri_reg)),
        .term_d (SUM_W'(rd_reg)),
        .axis   (roll_axis)
    );

    qapm_axis_div #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_div_pitch (
        .aclk   (aclk),
        .en     (div_en),
        .term_p (SUM_W'(pp_reg)),
        .term_i (SUM_W'(pi_reg)),
        .term_d (SUM_W'(pd_reg)),
        .axis   (pitch_axis)
    );

    qapm_axis_div #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_div_yaw (
        .aclk   (aclk),
        .en     (div_en),
        .term_p (SUM_W'(yp_reg)),
        .term_i ('0),
        .term_d (SUM_W'(yd_reg)),
        .axis   (yaw_axis)
    );

    qapm_mixer #(.AXIS_W(AXIS_W)) u_mixer (
        .thr    (thr_pipe_reg[ST_QUO]),
        .roll   (roll_axis),
        .pitch  (pitch_axis),
        .yaw    (yaw_axis),
        .motors (mix_out)
    );

    // Control, gains and controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg            <= '0;
            roll_kp_reg        <= RST_ROLL_KP;
            roll_ki_reg        <= RST_ROLL_KI;
            roll_kd_reg        <= RST_ROLL_KD;
            pitch_kp_reg       <= RST_PITCH_KP;
            pitch_ki_reg       <= RST_PITCH_KI;
            pitch_kd_reg       <= RST_PITCH_KD;
            yaw_kp_reg         <= RST_YAW_KP;
            yaw_kd_reg         <= RST_YAW_KD;
            roll_accum_reg     <= '0;
            pitch_accum_reg    <= '0;
            prev_roll_err_reg  <= '0;
            prev_pitch_err_reg <= '0;
            prev_yaw_err_reg   <= '0;
        end else begin
            vld_reg <= vld_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_ROLL_KP:  roll_kp_reg  <= cfg_data;
                    REG_ROLL_KI:  roll_ki_reg  <= cfg_data;
                    REG_ROLL_KD:  roll_kd_reg  <= cfg_data;
                    REG_PITCH_KP: pitch_kp_reg <= cfg_data;
                    REG_PITCH_KI: pitch_ki_reg <= cfg_data;
                    REG_PITCH_KD: pitch_kd_reg <= cfg_data;
                    REG_YAW_KP:   yaw_kp_reg   <= cfg_data;
                    REG_YAW_KD:   yaw_kd_reg   <= cfg_data;
                    default: ;
                endcase
            end
            // State moves only when a real transaction enters the integrator stage
            if (adv[ST_INT] && vld_reg[ST_ERR]) begin
                roll_accum_reg     <= roll_accum_next;
                pitch_accum_reg    <= pitch_accum_next;
                prev_roll_err_reg  <= er1_reg;
                prev_pitch_err_reg <= ep1_reg;
                prev_yaw_err_reg   <= ey1_reg;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (adv[ST_IN]) begin
            in_reg <= s_data;
        end
        if (adv[ST_ERR]) begin
            er1_reg              <= er_comb;
            ep1_reg              <= ep_comb;
            ey1_reg              <= ey_comb;
            thr_pipe_reg[ST_ERR] <= in_reg.stick_throttle;
        end
        for (int k = ST_ERR + 1; k <= ST_QUO; k++) begin
            if (adv[k]) begin
                thr_pipe_reg[k] <= thr_pipe_reg[k - 1];
            end
        end
        if (adv[ST_INT]) begin
            er2_reg    <= er1_reg;
            ep2_reg    <= ep1_reg;
            ey2_reg    <= ey1_reg;
            racc2_reg  <= roll_accum_next;
            pacc2_reg  <= pitch_accum_next;
            rdiff2_reg <= DIFF_W'(er1_reg) - DIFF_W'(prev_roll_err_reg);
            pdiff2_reg <= DIFF_W'(ep1_reg) - DIFF_W'(prev_pitch_err_reg);
            ydiff2_reg <= DIFF_W'(ey1_reg) - DIFF_W'(prev_yaw_err_reg);
        end
        if (adv[ST_MUL]) begin
            rp_reg <= rp_prod;
            ri_reg <= ri_prod;
            rd_reg <= rd_prod;
            pp_reg <= pp_prod;
            pi_reg <= pi_prod;
            pd_reg <= pd_prod;
            yp_reg <= yp_prod;
            yd_reg <= yd_prod;
        end
        if (adv[ST_OUT]) begin
            out_reg <= mix_out;
        end
    end

endmodule

FILE: rtl/qapm_checker.sv
`timescale 1ns / 1ps

module qapm_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic                m_valid,
    input  logic                m_ready,
    input  qapm_pkg::qapm_out_t m_data
);
    import qapm_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    // Transactions accepted but not yet delivered
    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;

    always_comb begin
        inflight_next = inflight_reg;
        if (s_valid && s_ready) begin
            inflight_next = inflight_next + CNT_W'(1);
        end
        if (m_valid && m_ready) begin
            inflight_next = inflight_next - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> inflight_reg != '0)
        else $error("result presented with no transaction in flight");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more transactions in flight than pipeline stages");

    a_free_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled although output stage is free");

endmodule

bind quad_attitude_pid_mixer_unit qapm_checker u_qapm_checker (.*);
